### hw/rtl/ohash_pkg.sv
// package for the one-at-a-time bucket hash
// widths, back-end state type, queue status and the hash mixing functions
// no dependencies
`default_nettype none

package ohash_pkg;

    // sizing
    localparam int MAX_TABLE_SIZE = 65536;
    localparam int CFG_W          = 17;
    localparam int TSR_W          = $clog2(MAX_TABLE_SIZE + 1);
    localparam int DIV_W          = $clog2(MAX_TABLE_SIZE);
    localparam int HASH_W         = 32;
    localparam int CNT_W          = $clog2(HASH_W);
    localparam int BKT_W          = 16;
    localparam int KEY_W          = 8;
    localparam int RST_TABLE_SIZE = 256;

    // back-end sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_ABS,
        S_DIV,
        S_FIX,
        S_OUT
    } t_back_state;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // add a sign-extended byte, then shift-add-xor
    function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                   input logic signed [KEY_W-1:0] b);
        logic [HASH_W-1:0] t;
        t = h + HASH_W'(signed'(b));
        t = t + (t << 10);
        t = t ^ HASH_W'($signed(t) >>> 6);
        return t;
    endfunction

    // end-of-key avalanche
    function automatic logic [HASH_W-1:0] finalize(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h + (h << 3);
        t = t ^ HASH_W'($signed(t) >>> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ohash_if.sv
// request channel interfaces for the one-at-a-time bucket hash
// depends on ohash_pkg
`default_nettype none

// key byte channel
interface ohash_in_if;
    import ohash_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key_byte;
    logic                    has_byte;
    logic                    last_byte;

    modport source (output valid, output key_byte, output has_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input key_byte, input has_byte, input last_byte,
                    output ready);
endinterface

// bucket index channel
interface ohash_out_if;
    import ohash_pkg::*;
    logic             valid;
    logic             ready;
    logic [BKT_W-1:0] bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

`default_nettype wire

### hw/rtl/ohash_queue.sv
// two-entry queue of mixed hashes between front and back
// depends on ohash_pkg
`default_nettype none

module ohash_queue
    import ohash_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [HASH_W-1:0] i_push_hash,
    input  wire logic              i_pop,
    output logic      [HASH_W-1:0] o_head,
    output t_q_status              o_status
);

    logic [HASH_W-1:0] r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_hash;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

endmodule

`default_nettype wire

### hw/rtl/ohash_front.sv
// front end: takes key bytes, mixes them into the running hash
// pushes the mixed hash of each completed key to the queue; depends on ohash_pkg, ohash_if
`default_nettype none

module ohash_front
    import ohash_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ohash_in_if.sink               i_in,
    input  wire t_q_status         i_q_status,
    output logic                   o_push,
    output logic      [HASH_W-1:0] o_push_hash
);

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] mixed;
    logic              accept;

    // space for a finished key is always kept
    assign i_in.ready = ~i_q_status.full;
    assign accept     = i_in.valid & i_in.ready;

    // mix the byte when present
    always_comb begin
        if (i_in.has_byte) begin
            mixed = mix_byte(r_hash, i_in.key_byte);
        end else begin
            mixed = r_hash;
        end
    end

    // running hash, cleared after each key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_hash <= '0;
            end else begin
                r_hash <= mixed;
            end
        end
    end

    assign o_push      = accept & i_in.last_byte;
    assign o_push_hash = mixed;

endmodule

`default_nettype wire

### hw/rtl/ohash_back.sv
// back end: finalizes a hash, takes the signed remainder, drives the result request
// bit-serial restoring divider, one quotient bit a cycle; depends on ohash_pkg, ohash_if
`default_nettype none

module ohash_back
    import ohash_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [TSR_W-1:0]  i_table_size,
    input  wire t_q_status         i_q_status,
    input  wire logic [HASH_W-1:0] i_head,
    output logic                   o_pop,
    ohash_out_if.source            o_out
);

    t_back_state       r_state, n_state;
    logic [HASH_W-1:0] r_h;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [BKT_W-1:0]  r_bucket;
    logic [DIV_W-1:0]  divisor;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    rem_sub;
    logic              rem_ge;
    logic [TSR_W-1:0]  bucket;

    assign divisor = DIV_W'(i_table_size - TSR_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_q_status.empty) n_state = S_FIN;
            S_FIN:   n_state = S_ABS;
            S_ABS:   n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(HASH_W - 1)) n_state = S_FIX;
            S_FIX:   n_state = S_OUT;
            S_OUT:   if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            S_IDLE:  o_pop = ~i_q_status.empty;
            S_OUT:   o_out.valid = 1'b1;
            default: begin
                o_pop       = 1'b0;
                o_out.valid = 1'b0;
            end
        endcase
    end

    assign o_out.bucket_index = r_bucket;

    // one restoring division step
    always_comb begin
        rem_sh  = {r_rem, r_h[HASH_W-1]};
        rem_ge  = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};
    end

    // negative remainder wraps into the table
    always_comb begin
        if (r_neg && (r_rem != '0)) begin
            bucket = i_table_size - TSR_W'(r_rem);
        end else begin
            bucket = TSR_W'(r_rem);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_h <= i_head;
            end
            S_FIN: begin
                r_h <= finalize(r_h);
            end
            S_ABS: begin
                r_neg <= r_h[HASH_W-1];
                r_h   <= r_h[HASH_W-1] ? (HASH_W'(0) - r_h) : r_h;
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= rem_ge ? DIV_W'(rem_sub) : DIV_W'(rem_sh);
                r_h   <= r_h << 1;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_FIX: begin
                r_bucket <= BKT_W'(bucket);
            end
            default: begin
                r_h <= r_h;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/one_at_a_time_bucket_hash.sv
// one-at-a-time bucket hash, top level
// holds the table size register and joins front, queue and back; depends on ohash_pkg, ohash_if
//
// usage: i_in carries one key byte per request (key_byte, has_byte, last_byte).
//   A request with last_byte set ends the key and yields one bucket_index on o_out;
//   other requests give no result. has_byte clear with last_byte set hashes
//   the key as it stands (the empty key right after reset or after a key ends).
//   Table size is written through i_cfg_wr_en / i_cfg_wr_data while idle;
//   values below 2 or above 65536 are clamped.
// timing: key bytes are taken one per cycle while the two-entry key queue has room.
//   o_out.valid rises after the request that ends a key is taken and the key passes
//   queue pop, finalize, magnitude, a one-bit-per-cycle divider and fixup; the back
//   end holds one key at a time and pops the next only after o_out is taken.
// reset: synchronous, active low; clears the running hash, the queue and the back
//   end, and sets the table size to 256.
// stall: a result holds on o_out until taken; meanwhile bytes of later keys are
//   still taken until the queue is full.
`default_nettype none

module one_at_a_time_bucket_hash
    import ohash_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    ohash_in_if.sink              i_in,
    ohash_out_if.source           o_out
);

    logic [TSR_W-1:0]  r_table_size;
    logic [TSR_W-1:0]  n_table_size;
    logic              push, pop;
    logic [HASH_W-1:0] push_hash, head;
    t_q_status         q_status;

    // clamp the written table size
    always_comb begin
        if (32'(i_cfg_wr_data) < 32'd2) begin
            n_table_size = TSR_W'(2);
        end else if (32'(i_cfg_wr_data) > 32'(MAX_TABLE_SIZE)) begin
            n_table_size = TSR_W'(MAX_TABLE_SIZE);
        end else begin
            n_table_size = TSR_W'(i_cfg_wr_data);
        end
    end

    // table size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TSR_W'(RST_TABLE_SIZE);
        end else if (i_cfg_wr_en) begin
            r_table_size <= n_table_size;
        end
    end

    // byte intake and mixing
    ohash_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_hash (push_hash)
    );

    // finished keys waiting for the back end
    ohash_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_hash (push_hash),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    // finalize, remainder, result
    ohash_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_table_size (r_table_size),
        .i_q_status   (q_status),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire
